// ----- hdl/ccc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock calendar package
// Shared types, codes and the weekday arithmetic of the clock calendar counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

   localparam int unsigned TicksWidth = 16;
   localparam logic [TicksWidth-1:0] TicksReset = 16'd1000;

   typedef enum logic [1:0] {
      MODE_RUN   = 2'd0,
      MODE_PAUSE = 2'd1,
      MODE_DOWN  = 2'd2
   } mode_type;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   localparam logic [4:0] KEY_YEAR   = 5'd1;
   localparam logic [4:0] KEY_MONTH  = 5'd2;
   localparam logic [4:0] KEY_DAY    = 5'd3;
   localparam logic [4:0] KEY_HOUR   = 5'd4;
   localparam logic [4:0] KEY_MINUTE = 5'd5;
   localparam logic [4:0] KEY_SECOND = 5'd6;
   localparam logic [4:0] KEY_CLEAR  = 5'd15;
   localparam logic [4:0] KEY_MODE   = 5'd16;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } time_type;

   localparam time_type TimeReset = '{year: 7'd1, month: 4'd1, day: 5'd1,
                                      hour: 5'd0, minute: 6'd0, second: 6'd0};

   // Month term of the weekday formula: 26 * (month + 1) / 10.
   function automatic logic [5:0] month_term(input logic [3:0] month);
      logic [5:0] term;
      case (month)
         4'd0:    term = 6'd2;
         4'd1:    term = 6'd5;
         4'd2:    term = 6'd7;
         4'd3:    term = 6'd10;
         4'd4:    term = 6'd13;
         4'd5:    term = 6'd15;
         4'd6:    term = 6'd18;
         4'd7:    term = 6'd20;
         4'd8:    term = 6'd23;
         4'd9:    term = 6'd26;
         4'd10:   term = 6'd28;
         4'd11:   term = 6'd31;
         4'd12:   term = 6'd33;
         4'd13:   term = 6'd36;
         4'd14:   term = 6'd39;
         default: term = 6'd41;
      endcase
      return term;
   endfunction

   // The offset of minus 36 is raised by 42 so the sum stays non-negative
   // without changing its residue modulo 7. The residue is then folded in
   // octal digits, since 8 is 1 modulo 7.
   function automatic logic [2:0] weekday(input time_type t);
      logic [7:0] sum;
      logic [4:0] fold1;
      logic [3:0] fold2;
      logic [2:0] result;
      sum = 8'(t.year) + 8'(t.year[6:2]) + 8'(month_term(t.month)) + 8'(t.day) + 8'd6;
      fold1 = 5'(sum[7:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
      fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
      if (fold2 >= 4'd7) begin
         result = 3'(fold2 - 4'd7);
      end else begin
         result = fold2[2:0];
      end
      return result;
   endfunction

endpackage

// ----- hdl/ccc_next.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock calendar next state
// Prescaler, carry and borrow chains, key handling and mode stepping for one
// tick or key transfer.
// ----------------------------------------------------------------------------
module ccc_next
   import ccc_pkg::*;
(
   input  time_type                cur_time,
   input  mode_type                cur_mode,
   input  logic [TicksWidth-1:0]   cur_prescale,
   input  logic [TicksWidth-1:0]   ticks_per_second,
   input  logic                    command,
   input  logic [4:0]              key_code,
   output time_type                nxt_time,
   output mode_type                nxt_mode,
   output logic [TicksWidth-1:0]   nxt_prescale
);

   logic [TicksWidth-1:0] prescale_inc;
   logic                  is_tick;
   logic                  is_key;
   logic                  second_event;
   logic                  key_edit;
   logic                  up_sec, up_min, up_hour, up_day, up_month, up_year;
   logic                  wrap_sec, wrap_min, wrap_hour, wrap_day, wrap_month;
   logic                  dn_sec, dn_min, dn_hour, dn_day, dn_month, dn_year;
   time_type              up_time;
   time_type              dn_time;

   assign is_tick      = (command == CMD_TICK);
   assign is_key       = (command == CMD_KEY);
   assign prescale_inc = cur_prescale + 1'b1;
   assign second_event = is_tick && (prescale_inc >= ticks_per_second);
   assign nxt_prescale = !is_tick ? cur_prescale : (second_event ? '0 : prescale_inc);

   assign key_edit = is_key && (cur_mode == MODE_RUN || cur_mode == MODE_PAUSE);

   assign up_sec   = (second_event && cur_mode == MODE_RUN)
                     || (key_edit && key_code == KEY_SECOND);
   assign wrap_sec = up_sec && cur_time.second == 6'd59;
   assign up_min   = wrap_sec || (key_edit && key_code == KEY_MINUTE);
   assign wrap_min = up_min && cur_time.minute == 6'd59;
   assign up_hour  = wrap_min || (key_edit && key_code == KEY_HOUR);
   assign wrap_hour = up_hour && cur_time.hour == 5'd23;
   assign up_day   = wrap_hour || (key_edit && key_code == KEY_DAY);
   assign wrap_day = up_day && cur_time.day == 5'd30;
   assign up_month = wrap_day || (key_edit && key_code == KEY_MONTH);
   assign wrap_month = up_month && cur_time.month == 4'd12;
   assign up_year  = wrap_month || (key_edit && key_code == KEY_YEAR);

   always_comb begin
      up_time = cur_time;
      if (up_sec) begin
         up_time.second = wrap_sec ? 6'd0 : cur_time.second + 6'd1;
      end
      if (up_min) begin
         up_time.minute = wrap_min ? 6'd0 : cur_time.minute + 6'd1;
      end
      if (up_hour) begin
         up_time.hour = wrap_hour ? 5'd0 : cur_time.hour + 5'd1;
      end
      if (up_day) begin
         up_time.day = wrap_day ? 5'd1 : cur_time.day + 5'd1;
      end
      if (up_month) begin
         up_time.month = wrap_month ? 4'd1 : cur_time.month + 4'd1;
      end
      if (up_year) begin
         up_time.year = (cur_time.year == 7'd99) ? 7'd0 : cur_time.year + 7'd1;
      end
   end

   assign dn_sec   = second_event && cur_mode == MODE_DOWN;
   assign dn_min   = dn_sec && cur_time.second == 6'd0;
   assign dn_hour  = dn_min && cur_time.minute == 6'd0;
   assign dn_day   = dn_hour && cur_time.hour == 5'd0;
   assign dn_month = dn_day && cur_time.day <= 5'd1;
   assign dn_year  = dn_month && cur_time.month <= 4'd1;

   always_comb begin
      dn_time = cur_time;
      if (dn_sec) begin
         dn_time.second = (cur_time.second == 6'd0) ? 6'd59 : cur_time.second - 6'd1;
      end
      if (dn_min) begin
         dn_time.minute = (cur_time.minute == 6'd0) ? 6'd59 : cur_time.minute - 6'd1;
      end
      if (dn_hour) begin
         dn_time.hour = (cur_time.hour == 5'd0) ? 5'd23 : cur_time.hour - 5'd1;
      end
      if (dn_day) begin
         dn_time.day = (cur_time.day <= 5'd1) ? 5'd30 : cur_time.day - 5'd1;
      end
      if (dn_month) begin
         dn_time.month = (cur_time.month <= 4'd1) ? 4'd12 : cur_time.month - 4'd1;
      end
      if (dn_year) begin
         dn_time.year = (cur_time.year == 7'd0) ? 7'd99 : cur_time.year - 7'd1;
      end
   end

   always_comb begin
      if (is_key && key_code == KEY_CLEAR) begin
         nxt_time = TimeReset;
      end else if (dn_sec) begin
         nxt_time = dn_time;
      end else begin
         nxt_time = up_time;
      end
   end

   always_comb begin
      nxt_mode = cur_mode;
      if (is_key && key_code == KEY_MODE) begin
         unique case (cur_mode)
            MODE_RUN:   nxt_mode = MODE_PAUSE;
            MODE_PAUSE: nxt_mode = MODE_DOWN;
            default:    nxt_mode = MODE_RUN;
         endcase
      end
   end

endmodule

// ----- hdl/clock_calendar_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock calendar counter
// Real-time clock and calendar with thirty-day months, a pause mode and a
// countdown mode, driven by tick and key transfers.
// ----------------------------------------------------------------------------
// Pipeline: a request is held in the request register until the result register can
// load; its result is then registered and transfers while rsp_stall is low.
// Throughput: one request per cycle while rsp_stall is low; the calendar update for one
// request is combinational between the request register and the result register.
// Reset: synchronous; the calendar goes to 01-01-01 00:00:00, mode to running,
// the prescaler to zero and ticks_per_second to 1000.
module clock_calendar_counter
   import ccc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [4:0]            req_key_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [5:0]            rsp_seconds_now,
   output logic [5:0]            rsp_minutes_now,
   output logic [4:0]            rsp_hours_now,
   output logic [4:0]            rsp_day_now,
   output logic [3:0]            rsp_month_now,
   output logic [6:0]            rsp_year_now,
   output logic [2:0]            rsp_weekday_now,
   output logic [1:0]            rsp_mode_now,
   output logic                  rsp_odd_second,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TicksWidth-1:0] csr_ticks_per_second
);

   logic                  in_valid_ff;
   logic                  in_command_ff;
   logic [4:0]            in_key_ff;
   time_type              time_ff;
   time_type              time_in;
   mode_type              mode_ff;
   mode_type              mode_in;
   logic [TicksWidth-1:0] prescale_ff;
   logic [TicksWidth-1:0] prescale_in;
   logic [TicksWidth-1:0] tps_ff;
   logic                  rsp_valid_ff;
   time_type              rsp_time_ff;
   logic [2:0]            rsp_weekday_ff;
   mode_type              rsp_mode_ff;
   logic                  rsp_load;
   logic                  step;
   logic                  req_take;

   ccc_next u_next (
      .cur_time         (time_ff),
      .cur_mode         (mode_ff),
      .cur_prescale     (prescale_ff),
      .ticks_per_second (tps_ff),
      .command          (in_command_ff),
      .key_code         (in_key_ff),
      .nxt_time         (time_in),
      .nxt_mode         (mode_in),
      .nxt_prescale     (prescale_in)
   );

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && rsp_load;
   assign req_stall = in_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= TimeReset;
         mode_ff      <= MODE_RUN;
         prescale_ff  <= '0;
         tps_ff       <= TicksReset;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (step) begin
            time_ff     <= time_in;
            mode_ff     <= mode_in;
            prescale_ff <= prescale_in;
         end
         if (csr_valid && csr_ready) begin
            tps_ff <= csr_ticks_per_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_key_ff     <= req_key_code;
      end
      if (step) begin
         rsp_time_ff    <= time_in;
         rsp_weekday_ff <= weekday(time_in);
         rsp_mode_ff    <= mode_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seconds_now = rsp_time_ff.second;
   assign rsp_minutes_now = rsp_time_ff.minute;
   assign rsp_hours_now   = rsp_time_ff.hour;
   assign rsp_day_now     = rsp_time_ff.day;
   assign rsp_month_now   = rsp_time_ff.month;
   assign rsp_year_now    = rsp_time_ff.year;
   assign rsp_weekday_now = rsp_weekday_ff;
   assign rsp_mode_now    = rsp_mode_ff;
   assign rsp_odd_second  = rsp_time_ff.second[0];

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty request register");

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed request did not produce a result");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      time_ff.second < 6'd60 && time_ff.minute < 6'd60 && time_ff.hour < 5'd24
      && time_ff.year < 7'd100)
      else $error("time of day or year out of range");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      time_ff.day >= 5'd1 && time_ff.day <= 5'd30
      && time_ff.month >= 4'd1 && time_ff.month <= 4'd12)
      else $error("day or month out of range");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_weekday_ff < 3'd7)
      else $error("weekday out of range");

endmodule
